// File: hdl/assert_macros.svh
// Assertion helper macros for the Catmull-Rom window interpolator.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: hdl/crwi_pkg.sv
// Shared types and constants of the Catmull-Rom window interpolator.
// Depends on nothing.
`default_nettype none
package crwi_pkg;

  localparam int WindowPoints    = 4;
  localparam int MaxPointsDefault = 64;
  localparam int QueueDepthDefault = 2;

  localparam logic [20:0] AccumMax = 21'h1FFFFF;

  localparam logic [19:0] PeriodReset = 20'd1000000;
  localparam logic [16:0] StepReset   = 17'd6554;

  // register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TIMED  = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;
  localparam logic [1:0] CFG_STEP   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ADD_PLAIN = 2'd0;
  localparam logic [1:0] ST_ADD_NEWWIN = 2'd1;
  localparam logic [1:0] ST_CURVE      = 2'd2;
  localparam logic [1:0] ST_REFUSED    = 2'd3;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REFUSE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic                   new_win;
    logic [16:0]            start_param;
    logic [16:0]            end_param;
    logic [3:0][31:0]       wx;
    logic [3:0][31:0]       wy;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/crwi_ifs.sv
// Handshake interfaces: input words, result words and config writes.
// Depends on nothing.
`default_nettype none
interface crwi_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [19:0] delta_time_us;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [16:0] start_param;
  logic [16:0] end_param;
  modport source (output valid, action, delta_time_us, pos_x, pos_y, start_param,
                  end_param, input ready);
  modport sink (input valid, action, delta_time_us, pos_x, pos_y, start_param,
                end_param, output ready);
endinterface

interface crwi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic        last;
  modport source (output valid, status, out_x, out_y, last, input ready);
  modport sink (input valid, status, out_x, out_y, last, output ready);
endinterface

interface crwi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/crwi_front.sv
// Front end: takes input words, keeps window, time total and read flag.
// Depends on crwi_pkg and crwi_ifs; feeds commands into crwi_queue.
`default_nettype none
`include "assert_macros.svh"
module crwi_front import crwi_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  crwi_in_if.sink     in_i,
  input  wire logic   enable_i,
  input  wire logic   timed_i,
  input  wire logic [19:0] period_i,
  input  wire logic   q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [3:0][31:0] wx_q, wx_d, wy_q, wy_d;
  logic [2:0]  fill_q, fill_d;
  logic [20:0] time_q, time_d;
  logic        armed_q, armed_d;
  logic [21:0] sum;
  logic [20:0] acc_sat;
  logic        take, do_store;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    sum      = {1'b0, time_q} + {2'b0, in_i.delta_time_us};
    acc_sat  = (sum > {1'b0, AccumMax}) ? AccumMax : sum[20:0];
    take     = acc_sat > {1'b0, period_i};
    do_store = enable_i && (!timed_i || take);

    wx_d = wx_q; wy_d = wy_q; fill_d = fill_q; time_d = time_q; armed_d = armed_q;
    cmd_o = '0;
    cmd_o.kind = CMD_ADD;
    cmd_o.start_param = in_i.start_param;
    cmd_o.end_param   = in_i.end_param;
    cmd_o.wx = wx_q;
    cmd_o.wy = wy_q;

    if (in_i.action == ACT_ADD) begin
      if (enable_i && timed_i) begin
        time_d = take ? '0 : acc_sat;
      end
      if (do_store) begin
        if (fill_q < 3'(WindowPoints)) begin
          wx_d[fill_q[1:0]] = in_i.pos_x;
          wy_d[fill_q[1:0]] = in_i.pos_y;
          fill_d = fill_q + 3'd1;
        end else begin
          wx_d = {in_i.pos_x, wx_q[3:1]};
          wy_d = {in_i.pos_y, wy_q[3:1]};
          armed_d = 1'b1;
          cmd_o.new_win = 1'b1;
        end
      end
    end else if (armed_q) begin
      cmd_o.kind = CMD_READ;
      armed_d = 1'b0;
    end else begin
      cmd_o.kind = CMD_REFUSE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= '0; wy_q <= '0; fill_q <= '0; time_q <= '0; armed_q <= 1'b0;
    end else if (push_o) begin
      wx_q <= wx_d; wy_q <= wy_d; fill_q <= fill_d; time_q <= time_d;
      armed_q <= armed_d;
    end
  end

  `ASSERT_AT(a_armed_full, clk_i, rst_ni, armed_q |-> (fill_q == 3'(WindowPoints)), "armed w/o full window")

endmodule
`default_nettype wire

// File: hdl/crwi_queue.sv
// Short command queue between front and back end.
// Depends on crwi_pkg.
`default_nettype none
`include "assert_macros.svh"
module crwi_queue import crwi_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign cmd_o   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")

endmodule
`default_nettype wire

// File: hdl/crwi_back.sv
// Back end: evaluates curve points on one shared 24x32 multiplier, drives results.
// Depends on crwi_pkg and crwi_ifs; reads commands from crwi_queue.
`default_nettype none
`include "assert_macros.svh"
module crwi_back import crwi_pkg::*; #(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [16:0] step_i,
  input  wire logic q_empty_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  crwi_out_if.source out_o
);

  localparam int CntW = $clog2(MaxPoints + 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQ   = 10'b0000000010,
    ST_S2   = 10'b0000000100,
    ST_CU   = 10'b0000001000,
    ST_S3   = 10'b0000010000,
    ST_WGT  = 10'b0000100000,
    ST_MUL  = 10'b0001000000,
    ST_ACC  = 10'b0010000000,
    ST_FIN  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0][31:0] wx_q, wy_q;
  logic [16:0] end_q;
  logic [17:0] m_q, m_d, m_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic        is_read_q, is_read_d;
  logic [1:0]  res_st_q, res_st_d;
  logic signed [31:0] rx_q, rx_d, ry_q, ry_d;
  logic [18:0] s2_q, s2_d;
  logic [19:0] s3_q, s3_d;
  logic signed [23:0] w_q [4];
  logic signed [23:0] w_d [4];
  logic signed [55:0] prod_q, prod_d;
  logic signed [59:0] acc_q, acc_d;
  logic [2:0]  k_q, k_d;
  logic signed [23:0] mul_a, sx, s2x, s3x;
  logic signed [31:0] mul_b;
  logic signed [55:0] rnd;
  logic signed [59:0] t, r;
  logic signed [31:0] sat;
  logic        slot_free, emit_last, load;
  logic        ovalid_q;
  logic [1:0]  ost_q;
  logic signed [31:0] ox_q, oy_q;
  logic        olast_q;

  assign slot_free = !ovalid_q || out_o.ready;
  assign m_next    = m_q + {1'b0, step_i};
  assign emit_last = !is_read_q || (m_next >= {1'b0, end_q}) ||
                     (cnt_q == CntW'(MaxPoints - 1));
  assign load      = (state_q == ST_EMIT) && slot_free;

  assign sx  = {7'b0, m_q[16:0]};
  assign s2x = {5'b0, s2_q};
  assign s3x = {4'b0, s3_q};

  always_comb begin
    unique case (state_q)
      ST_SQ:   begin mul_a = sx;  mul_b = {15'b0, m_q[16:0]}; end
      ST_CU:   begin mul_a = s2x; mul_b = {15'b0, m_q[16:0]}; end
      default: begin
        mul_a = w_q[k_q[1:0]];
        mul_b = k_q[2] ? wy_q[k_q[1:0]] : wx_q[k_q[1:0]];
      end
    endcase
  end

  always_comb begin
    rnd = prod_q + 56'sd32768;
    t   = acc_q + 60'sd65536;
    r   = t >>> 17;
    if (r > 60'sd2147483647) sat = 32'sh7FFFFFFF;
    else if (r < -60'sd2147483648) sat = 32'sh80000000;
    else sat = r[31:0];
  end

  always_comb begin
    state_d = state_q; m_d = m_q; cnt_d = cnt_q; is_read_d = is_read_q;
    res_st_d = res_st_q; rx_d = rx_q; ry_d = ry_q; s2_d = s2_q; s3_d = s3_q;
    w_d = w_q; prod_d = prod_q; acc_d = acc_q; k_d = k_q;
    pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          m_d = {1'b0, cmd_i.start_param};
          cnt_d = '0; k_d = '0; acc_d = '0;
          rx_d = '0; ry_d = '0;
          is_read_d = cmd_i.kind == CMD_READ;
          unique case (cmd_i.kind)
            CMD_READ: begin
              res_st_d = ST_CURVE;
              // empty range: nothing to emit
              if (cmd_i.start_param < cmd_i.end_param) state_d = ST_SQ;
            end
            CMD_REFUSE: begin res_st_d = ST_REFUSED; state_d = ST_EMIT; end
            default: begin
              res_st_d = cmd_i.new_win ? ST_ADD_NEWWIN : ST_ADD_PLAIN;
              state_d  = ST_EMIT;
            end
          endcase
        end
      end
      ST_SQ:  begin prod_d = mul_a * mul_b; state_d = ST_S2; end
      ST_S2:  begin s2_d = rnd[34:16]; state_d = ST_CU; end
      ST_CU:  begin prod_d = mul_a * mul_b; state_d = ST_S3; end
      ST_S3:  begin s3_d = rnd[35:16]; state_d = ST_WGT; end
      ST_WGT: begin
        w_d[0] = -s3x + (s2x <<< 1) - sx;
        w_d[1] = (s3x <<< 1) + s3x - (s2x <<< 2) - s2x + 24'sd131072;
        w_d[2] = -((s3x <<< 1) + s3x) + (s2x <<< 2) + sx;
        w_d[3] = s3x - s2x;
        state_d = ST_MUL;
      end
      ST_MUL: begin prod_d = mul_a * mul_b; state_d = ST_ACC; end
      ST_ACC: begin
        acc_d = acc_q + 60'(prod_q);
        if (k_q[1:0] == 2'd3) state_d = ST_FIN;
        else begin k_d = k_q + 3'd1; state_d = ST_MUL; end
      end
      ST_FIN: begin
        if (k_q[2]) ry_d = sat; else rx_d = sat;
        acc_d = '0;
        k_d = k_q + 3'd1;
        state_d = k_q[2] ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (is_read_q && !emit_last) begin
            m_d = m_next; cnt_d = cnt_q + CntW'(1); state_d = ST_SQ;
          end else state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; cnt_q <= cnt_d; is_read_q <= is_read_d; res_st_q <= res_st_d;
    rx_q <= rx_d; ry_q <= ry_d; s2_q <= s2_d; s3_q <= s3_d; w_q <= w_d;
    prod_q <= prod_d; acc_q <= acc_d; k_q <= k_d;
    if (pop_o) begin
      wx_q <= cmd_i.wx; wy_q <= cmd_i.wy; end_q <= cmd_i.end_param;
    end
    if (load) begin
      ost_q <= res_st_q; ox_q <= rx_q; oy_q <= ry_q; olast_q <= emit_last;
    end
  end

  assign out_o.valid  = ovalid_q;
  assign out_o.status = ost_q;
  assign out_o.out_x  = ox_q;
  assign out_o.out_y  = oy_q;
  assign out_o.last   = olast_q;

  `ASSERT_AT(a_last_idle, clk_i, rst_ni, (load && emit_last) |=> (state_q == ST_IDLE), "no idle")

endmodule
`default_nettype wire

// File: hdl/catmull_rom_window_interpolator.sv
// Top level of the Catmull-Rom window interpolator: config registers, front, queue, back.
// Depends on crwi_pkg, crwi_ifs, crwi_front, crwi_queue, crwi_back.
`default_nettype none
//  channel | dir | payload
//  in_i    | in  | action, delta_time_us, pos_x, pos_y, start_param, end_param
//  out_o   | out | status, out_x, out_y, last
//  cfg_i   | in  | index, data (write only, always ready)
//
// Add and refused-read words go from idle straight to the emit state.
// Each curve point steps through two multiplies for s^2 and s^3, weights,
// then eight multiply-accumulates on one 24x32 multiplier, x then y.
// The front keeps taking words while the command queue has room; result
// stalls hold the back end only. Reset is asynchronous and clears the
// control and config state; back-end datapath and queue memory are not reset.
module catmull_rom_window_interpolator import crwi_pkg::*; #(
  parameter int MAX_POINTS_PER_READ = MaxPointsDefault,
  parameter int QUEUE_DEPTH         = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crwi_in_if.sink    in_i,
  crwi_out_if.source out_o,
  crwi_cfg_if.sink   cfg_i
);

  logic        enable_q, timed_q;
  logic [19:0] period_q;
  logic [16:0] step_q;
  logic        push, full, pop, empty;
  cmd_t        cmd_in, cmd_out;

  // config writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      timed_q  <= 1'b0;
      period_q <= PeriodReset;
      step_q   <= StepReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ENABLE: enable_q <= cfg_i.data[0];
        CFG_TIMED:  timed_q  <= cfg_i.data[0];
        CFG_PERIOD: period_q <= cfg_i.data;
        CFG_STEP:   step_q   <= cfg_i.data[16:0];
        default: ;
      endcase
    end
  end

  crwi_front u_front (
    .clk_i, .rst_ni, .in_i,
    .enable_i(enable_q), .timed_i(timed_q), .period_i(period_q),
    .q_full_i(full), .push_o(push), .cmd_o(cmd_in)
  );

  crwi_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(cmd_out)
  );

  crwi_back #(.MaxPoints(MAX_POINTS_PER_READ)) u_back (
    .clk_i, .rst_ni, .step_i(step_q), .q_empty_i(empty), .cmd_i(cmd_out),
    .pop_o(pop), .out_o
  );

endmodule
`default_nettype wire
